@@ rtl/core/mvat_pkg.sv @@
`default_nettype none

package mvat_pkg;

    // field widths fixed by the request and result formats
    localparam int KIND_W   = 3;
    localparam int MAC_W    = 48;
    localparam int VLAN_W   = 12;
    localparam int STATUS_W = 2;
    localparam int SLOT_W   = 8;

    // request kinds
    localparam logic [KIND_W-1:0] KIND_ADD      = 3'd0;
    localparam logic [KIND_W-1:0] KIND_DEL_PAIR = 3'd1;
    localparam logic [KIND_W-1:0] KIND_DEL_MAC  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_DEL_VLAN = 3'd3;
    localparam logic [KIND_W-1:0] KIND_LOOKUP   = 3'd4;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOTFND = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL   = 2'd2;

    // one table entry as stored in memory
    typedef struct packed {
        logic              valid;
        logic [MAC_W-1:0]  mac;
        logic [VLAN_W-1:0] vlan;
    } t_entry;

endpackage

`default_nettype wire

@@ rtl/core/mvat_ifs.sv @@
`default_nettype none

// request channel: kind and key
interface mvat_req_if;
    import mvat_pkg::*;

    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic [MAC_W-1:0]  mac_address;
    logic [VLAN_W-1:0] vlan_id;

    modport source (output valid, output kind, output mac_address, output vlan_id,
                    input ready);
    modport sink   (input valid, input kind, input mac_address, input vlan_id,
                    output ready);
endinterface

// result channel: status and slot
interface mvat_rsp_if;
    import mvat_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot_index;

    modport source (output valid, output status, output slot_index, input ready);
    modport sink   (input valid, input status, input slot_index, output ready);
endinterface

`default_nettype wire

@@ rtl/core/mac_vlan_address_table.sv @@
// MAC address and VLAN table with TABLE_DEPTH slots.
// i_req (valid/ready) carries one request: kind, mac_address, vlan_id.
// o_rsp (valid/ready) returns one result per request: status, slot_index.
// Kinds: add into lowest free slot, delete exact pair, delete all entries with
// a given MAC, delete all entries with a given VLAN, lookup of a pair.
// Every request scans the whole table, one entry per cycle through the single
// read port of the entry memory; matches found on the way are cleared through
// the write port in the cycle after the read.
// The result is loaded into the output register as the sequencer leaves its
// finish state; a new request is taken only when the sequencer is idle again,
// so no request is taken while the previous one is still being scanned.
// Reset: a clearing pass writes every slot invalid, one slot per cycle;
// i_req.ready stays low during it.
// Stall: the result sits in an output register until o_rsp.ready; the next
// request is taken and scanned meanwhile, and its result waits at the end of
// the scan until the output register is free.
`default_nettype none

module mac_vlan_address_table #(
    parameter int TABLE_DEPTH = 256
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    mvat_req_if.sink     i_req,
    mvat_rsp_if.source   o_rsp
);
    import mvat_pkg::*;

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam logic [AW-1:0] LAST_ADDR = AW'(TABLE_DEPTH - 1);

    // sequencer states
    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_SCAN   = 3'd2;
    localparam logic [2:0] S_LAST   = 3'd3;
    localparam logic [2:0] S_FINISH = 3'd4;

    logic [2:0]          r_state;
    logic [2:0]          n_state;
    logic [AW-1:0]       r_addr;
    logic [AW-1:0]       r_cmp_addr;
    logic                r_cmp_vld;
    t_entry              r_rd_data;
    t_entry              r_mem [TABLE_DEPTH];

    logic [KIND_W-1:0]   r_kind;
    logic [MAC_W-1:0]    r_mac;
    logic [VLAN_W-1:0]   r_vlan;
    logic                r_found;
    logic [AW-1:0]       r_found_addr;

    logic                r_out_valid;
    logic [STATUS_W-1:0] r_out_status;
    logic [SLOT_W-1:0]   r_out_slot;

    logic                req_acc;
    logic                leave_finish;
    logic                mac_eq;
    logic                vlan_eq;
    logic                cand;
    logic                clr;
    logic                wr_en;
    logic [AW-1:0]       wr_addr;
    t_entry              wr_data;
    logic [STATUS_W-1:0] res_status;
    logic [SLOT_W-1:0]   res_slot;
    logic [AW+SLOT_W-1:0] found_ext;

    assign i_req.ready   = (r_state == S_IDLE);
    assign req_acc       = i_req.valid && i_req.ready;
    assign leave_finish  = (r_state == S_FINISH) && (!r_out_valid || o_rsp.ready);

    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.status     = r_out_status;
    assign o_rsp.slot_index = r_out_slot;

    // compare of the entry read in the previous cycle
    assign mac_eq  = (r_rd_data.mac == r_mac);
    assign vlan_eq = (r_rd_data.vlan == r_vlan);

    always_comb begin
        cand = 1'b0;
        clr  = 1'b0;
        case (r_kind)
            KIND_ADD:      cand = !r_rd_data.valid;
            KIND_DEL_PAIR: cand = r_rd_data.valid && mac_eq && vlan_eq;
            KIND_LOOKUP:   cand = r_rd_data.valid && mac_eq && vlan_eq;
            KIND_DEL_MAC:  clr  = r_rd_data.valid && mac_eq;
            KIND_DEL_VLAN: clr  = r_rd_data.valid && vlan_eq;
            default: begin
                cand = 1'b0;
                clr  = 1'b0;
            end
        endcase
    end

    // write port select: clearing pass, scan deletes, final add or delete
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_addr;
        wr_data = '{valid: 1'b0, mac: r_mac, vlan: r_vlan};
        if (r_state == S_CLEAR) begin
            wr_en = 1'b1;
        end else if (r_cmp_vld && clr) begin
            wr_en   = 1'b1;
            wr_addr = r_cmp_addr;
        end else if (leave_finish && r_found &&
                     (r_kind == KIND_ADD || r_kind == KIND_DEL_PAIR)) begin
            wr_en         = 1'b1;
            wr_addr       = r_found_addr;
            wr_data.valid = (r_kind == KIND_ADD);
        end
    end

    // result of the finished scan
    assign found_ext = {{SLOT_W{1'b0}}, r_found_addr};

    always_comb begin
        res_status = ST_NOTFND;
        res_slot   = '0;
        case (r_kind)
            KIND_ADD: begin
                res_status = r_found ? ST_OK : ST_FULL;
                res_slot   = r_found ? found_ext[SLOT_W-1:0] : '0;
            end
            KIND_DEL_PAIR: res_status = r_found ? ST_OK : ST_NOTFND;
            KIND_DEL_MAC:  res_status = ST_OK;
            KIND_DEL_VLAN: res_status = ST_OK;
            KIND_LOOKUP: begin
                res_status = r_found ? ST_OK : ST_NOTFND;
                res_slot   = r_found ? found_ext[SLOT_W-1:0] : '0;
            end
            default: begin
                res_status = ST_NOTFND;
                res_slot   = '0;
            end
        endcase
    end

    // sequencer next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR:  if (r_addr == LAST_ADDR) n_state = S_IDLE;
            S_IDLE:   if (req_acc) n_state = S_SCAN;
            S_SCAN:   if (r_addr == LAST_ADDR) n_state = S_LAST;
            S_LAST:   n_state = S_FINISH;
            S_FINISH: if (leave_finish) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // entry memory: one write, one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rd_data <= r_mem[r_addr];
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_addr      <= '0;
            r_cmp_vld   <= 1'b0;
            r_found     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cmp_vld <= (r_state == S_SCAN);
            if (r_state == S_CLEAR || r_state == S_SCAN) begin
                r_addr <= (r_addr == LAST_ADDR) ? '0 : r_addr + 1'b1;
            end
            if (req_acc) begin
                r_found <= 1'b0;
            end else if (r_cmp_vld && cand && !r_found) begin
                r_found <= 1'b1;
            end
            if (leave_finish) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_cmp_addr <= r_addr;
        if (req_acc) begin
            r_kind <= i_req.kind;
            r_mac  <= i_req.mac_address;
            r_vlan <= i_req.vlan_id;
        end
        if (r_cmp_vld && cand && !r_found) begin
            r_found_addr <= r_cmp_addr;
        end
        if (leave_finish) begin
            r_out_status <= res_status;
            r_out_slot   <= res_slot;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/mvat_checker.sv @@
`default_nettype none

module mvat_checker (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_req_valid,
    input  wire                          i_req_ready,
    input  wire                          i_rsp_valid,
    input  wire                          i_rsp_ready,
    input  wire [mvat_pkg::STATUS_W-1:0] i_rsp_status,
    input  wire [mvat_pkg::SLOT_W-1:0]   i_rsp_slot_index
);
    import mvat_pkg::*;

    // a stalled result holds its payload
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=>
            i_rsp_valid && $stable(i_rsp_status) && $stable(i_rsp_slot_index))
        else $error("stalled result changed");

    // one request at a time: not ready right after a request is taken
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && i_req_ready |=> !i_req_ready)
        else $error("request taken while scan in progress");

    // clearing pass after reset blocks requests
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_req_ready)
        else $error("ready during clearing pass");

    // failed results carry slot zero, status code is defined
    a_fail_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && (i_rsp_status == ST_NOTFND || i_rsp_status == ST_FULL) |->
            i_rsp_slot_index == '0)
        else $error("failed result with nonzero slot");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> (i_rsp_status == ST_OK || i_rsp_status == ST_NOTFND ||
                         i_rsp_status == ST_FULL))
        else $error("undefined status code");

endmodule

bind mac_vlan_address_table mvat_checker u_mvat_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_req_valid      (i_req.valid),
    .i_req_ready      (i_req.ready),
    .i_rsp_valid      (o_rsp.valid),
    .i_rsp_ready      (o_rsp.ready),
    .i_rsp_status     (o_rsp.status),
    .i_rsp_slot_index (o_rsp.slot_index)
);

`default_nettype wire
